// File: hdl/mats_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mats_pkg
// Shared constants and tables for the mirror angle to stepper step block.
// ----------------------------------------------------------------------------
package mats_pkg;

  // fixed point widths
  localparam int CW  = 20;   // cordic x, y, z
  localparam int SQW = 48;   // radicand of the length root
  localparam int RTW = 24;   // root result

  // cordic start vector (gain compensated) and iteration count
  localparam logic signed [CW-1:0] CORDIC_GAIN = 20'sd39797;
  localparam int                   CORDIC_N    = 16;

  // millidegree to radian scale in q16 (q32 before the shift)
  localparam logic [31:0] MDEG_TO_RAD = 32'd74961;
  localparam logic [31:0] RAD_ROUND   = 32'd32768;
  localparam int          ANGLE_LIMIT = 30000;

  // squared wire length terms
  localparam logic signed [33:0] SUM_SQ_Q = 34'sd424280064;  // 6474 in q16
  localparam logic signed [33:0] TWO_HR   = 34'sd4730;
  localparam logic signed [33:0] TWO_ER   = 34'sd3440;

  // flat length in q16 and length to microstep scale in q16
  localparam logic signed [24:0] FLAT_LEN   = 25'sd3609838;
  localparam logic signed [48:0] STEP_SCALE = 49'sd5960216;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_ENABLE = 2'd0;
  localparam logic [1:0] REG_OFFSET_MIRROR = 2'd1;
  localparam logic [1:0] REG_OFFSET_X      = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y      = 2'd3;

  // arctangent table in q16
  function automatic logic signed [CW-1:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    atan_q16 = 20'sd51472;
      4'd1:    atan_q16 = 20'sd30386;
      4'd2:    atan_q16 = 20'sd16055;
      4'd3:    atan_q16 = 20'sd8150;
      4'd4:    atan_q16 = 20'sd4091;
      4'd5:    atan_q16 = 20'sd2047;
      4'd6:    atan_q16 = 20'sd1024;
      4'd7:    atan_q16 = 20'sd512;
      4'd8:    atan_q16 = 20'sd256;
      4'd9:    atan_q16 = 20'sd128;
      4'd10:   atan_q16 = 20'sd64;
      4'd11:   atan_q16 = 20'sd32;
      4'd12:   atan_q16 = 20'sd16;
      4'd13:   atan_q16 = 20'sd8;
      4'd14:   atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

endpackage

// File: hdl/mats_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mats_cordic
// Iterative rotation cordic, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module mats_cordic
  import mats_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] sin_out,
  output logic signed [CW-1:0] cos_out,
  output logic                 done
);

  logic signed [CW-1:0] x, y, z;
  logic [3:0]           iter;
  logic                 run;
  logic signed [CW-1:0] dx, dy, da;

  // shared shift and add unit
  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign da = atan_q16(iter);

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
      end else if (run) begin
        iter <= iter + 4'd1;
        if (iter == 4'(CORDIC_N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= '0;
      z <= z_in;
    end else if (run) begin
      if (!z[CW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  assign sin_out = y;
  assign cos_out = x;

endmodule

// File: hdl/mats_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mats_sqrt
// Integer square root, one result bit per cycle from two radicand bits.
// ----------------------------------------------------------------------------
module mats_sqrt
  import mats_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [SQW-1:0] v_in,
  output logic [RTW-1:0] root,
  output logic           done
);

  localparam int RW = RTW + 3;

  logic [SQW-1:0] v;
  logic [RW-1:0]  rem;
  logic [4:0]     iter;
  logic           run;
  logic [RW-1:0]  rem_sh, trial;

  // next partial remainder and trial subtrahend
  assign rem_sh = {rem[RW-3:0], v[SQW-1:SQW-2]};
  assign trial  = {1'b0, root, 2'b01};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
      end else if (run) begin
        iter <= iter + 5'd1;
        if (iter == 5'(RTW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= v_in;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      v <= {v[SQW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RTW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RTW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/mirror_angle_to_stepper_steps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_angle_to_stepper_steps
// Mirror tilt angle to stepper microstep position with per-motor storage.
// ----------------------------------------------------------------------------
// each word goes through the iterative cordic and then the bit-serial root
//   in turn; a new word is taken only once the last has gone to the output
// s_tready is high only while the sequencer is idle
// reset: synchronous; clears the sequencer, m_tvalid, offsets and the stored angle and
//   step valid bits, so every motor reads as zero until first written
module mirror_angle_to_stepper_steps
  import mats_pkg::*;
#(
  parameter int MAX_MIRRORS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // motor_index[4:0], angle_mdeg[22:5]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // step_position[17:0], changed[18]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_MOTORS = 2 * MAX_MIRRORS;
  localparam int AW         = $clog2(NUM_MOTORS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_READ   = 11'b000_0000_0010,
    S_ANGLE  = 11'b000_0000_0100,
    S_RAD    = 11'b000_0000_1000,
    S_CORDIC = 11'b000_0001_0000,
    S_SQ1    = 11'b000_0010_0000,
    S_SQ2    = 11'b000_0100_0000,
    S_ROOT   = 11'b000_1000_0000,
    S_MUL    = 11'b001_0000_0000,
    S_ROUND  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic               offset_enable;
  logic [3:0]         offset_mirror;
  logic signed [15:0] offset_x, offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_enable <= 1'b0;
      offset_mirror <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_ENABLE: offset_enable <= cfg_data[0];
        REG_OFFSET_MIRROR: offset_mirror <= cfg_data[3:0];
        REG_OFFSET_X:      offset_x      <= cfg_data;
        REG_OFFSET_Y:      offset_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic [4:0]         idx;
  logic signed [17:0] req;
  logic               req_ok, motor_ok;
  logic [AW+4:0]      idx_wide;
  logic [AW-1:0]      addr;

  assign idx_wide = (AW + 5)'(idx);
  assign addr     = idx_wide[AW-1:0];
  assign req_ok   = (req > -18'sd30000) && (req < 18'sd30000);
  assign motor_ok = 32'(idx) < NUM_MOTORS;

  // per-motor stores with valid bits
  logic signed [15:0]    mem_angle [NUM_MOTORS];
  logic [17:0]           mem_last  [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] angle_vld, last_vld;
  logic signed [15:0]    rd_angle;
  logic [17:0]           rd_last;
  logic                  rd_angle_vld, rd_last_vld;
  logic                  wr_angle, wr_last, out_load;
  logic [17:0]           pos;

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign wr_angle = (state == S_ANGLE) && motor_ok && req_ok;
  assign wr_last  = out_load && motor_ok;

  always_ff @(posedge clk) begin
    rd_angle <= mem_angle[addr];
    rd_last  <= mem_last[addr];
    if (wr_angle) mem_angle[addr] <= req[15:0];
    if (wr_last)  mem_last[addr]  <= pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_vld    <= '0;
      last_vld     <= '0;
      rd_angle_vld <= 1'b0;
      rd_last_vld  <= 1'b0;
    end else begin
      rd_angle_vld <= angle_vld[addr];
      rd_last_vld  <= last_vld[addr];
      if (wr_angle) angle_vld[addr] <= 1'b1;
      if (wr_last)  last_vld[addr]  <= 1'b1;
    end
  end

  // angle to radians, feeds the cordic start
  logic signed [15:0] angle;
  logic [14:0]        mag;
  logic [31:0]        rad_prod;
  logic signed [CW-1:0] z_in, sin_v, cos_v;
  logic               cordic_done;

  assign mag      = angle[15] ? 15'(-angle) : angle[14:0];
  assign rad_prod = 32'(mag) * MDEG_TO_RAD + RAD_ROUND;
  assign z_in     = angle[15] ? -CW'(rad_prod[31:16]) : CW'(rad_prod[31:16]);

  mats_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_RAD),
    .z_in    (z_in),
    .sin_out (sin_v),
    .cos_out (cos_v),
    .done    (cordic_done)
  );

  // squared length, one product per cycle, clamped at zero
  logic signed [33:0] acc, acc2;
  logic [SQW-1:0]     sq_v;
  logic [RTW-1:0]     root;
  logic               sqrt_done;

  assign acc2 = acc - TWO_ER * 34'(cos_v);
  assign sq_v = acc2[33] ? '0 : {1'b0, acc2[30:0], 16'b0};

  mats_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQ2),
    .v_in  (sq_v),
    .root  (root),
    .done  (sqrt_done)
  );

  // length to microsteps
  logic signed [24:0] len;
  logic signed [48:0] prod;
  logic [48:0]        pmag;
  logic [49:0]        rsum;
  logic [17:0]        rstep, steps;
  logic signed [17:0] off_add;
  logic               off_hit;

  assign len     = $signed({1'b0, root}) - FLAT_LEN;
  assign pmag    = prod[48] ? 49'(-prod) : 49'(prod);
  assign rsum    = 50'(pmag) + 50'(1) * (50'd1 << 31);
  assign rstep   = rsum[49:32];
  assign off_hit = offset_enable && (idx[4:1] == offset_mirror);
  assign off_add = !off_hit ? 18'sd0 : (idx[0] ? 18'(offset_y) : 18'(offset_x));
  assign pos     = steps + 18'(off_add);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (s_tvalid) state <= S_READ;
        S_READ:   state <= S_ANGLE;
        S_ANGLE:  state <= S_RAD;
        S_RAD:    state <= S_CORDIC;
        S_CORDIC: if (cordic_done) state <= S_SQ1;
        S_SQ1:    state <= S_SQ2;
        S_SQ2:    state <= S_ROOT;
        S_ROOT:   if (sqrt_done) state <= S_MUL;
        S_MUL:    state <= S_ROUND;
        S_ROUND:  state <= S_DONE;
        S_DONE:   if (out_load) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx <= s_tdata[4:0];
        req <= s_tdata[22:5];
      end
      S_ANGLE: begin
        if (req_ok)                        angle <= req[15:0];
        else if (motor_ok && rd_angle_vld) angle <= rd_angle;
        else                               angle <= '0;
      end
      S_SQ1:   acc   <= SUM_SQ_Q - TWO_HR * 34'(sin_v);
      S_MUL:   prod  <= 49'(len) * STEP_SCALE;
      S_ROUND: steps <= prod[48] ? -rstep : rstep;
      S_DONE: begin
        if (out_load) begin
          m_tdata <= {5'b0,
                      motor_ok && (pos != (rd_last_vld ? rd_last : 18'd0)),
                      pos};
        end
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

// File: hdl/mats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mats_checker
// Port-level checks on the mirror angle to stepper step block.
// ----------------------------------------------------------------------------
module mats_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled output word stays valid
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // a stalled output word holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // the block goes busy after taking a word
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // padding above the changed flag is zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:19] == 5'b0)
    else $error("output padding not zero");

endmodule

bind mirror_angle_to_stepper_steps mats_checker u_mats_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mirror angle to stepper step block: directed
// table then random motor updates, checked against a local step predictor.
// ----------------------------------------------------------------------------
module tb;
  import mats_pkg::*;

  localparam int NUM_MOTORS = 32;
  localparam int WATCHDOG   = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_OFFSET_ENABLE;
  logic [15:0] cfg_data = '0;

  mirror_angle_to_stepper_steps DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] angle_mem [NUM_MOTORS];
  logic [17:0]        steps_mem [NUM_MOTORS];
  logic               ofs_en;
  logic [3:0]         ofs_mirror;
  logic signed [15:0] ofs_x, ofs_y;

  logic [18:0] pending_q [$];   // {changed, step_position}
  int errors = 0;
  int idle_cnt = 0;
  bit no_idle = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic int tilt_to_steps(int mdeg);
    longint mag, z, x, y, dx, dy, sq, len, prod, r;
    mag = (mdeg < 0) ? -mdeg : mdeg;
    z = (mag * 74961 + 32768) >>> 16;
    if (mdeg < 0) z = -z;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q16(i[3:0]);
      end else begin
        x += dx; y -= dy; z += atan_q16(i[3:0]);
      end
    end
    sq = (64'sd6474 << 16) - 4730 * y - 3440 * x;
    if (sq < 0) sq = 0;
    len = int_root(sq << 16) - int_root(64'd3034 << 32);
    prod = len * 5960216;
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (64'sd1 << 31)) >>> 32;
    return int'((prod < 0) ? -r : r);
  endfunction

  function automatic logic [18:0] predict_step(logic [4:0] idx, logic [17:0] raw);
    int req, ang, pos;
    logic [17:0] posu;
    logic chg;
    bit ok;
    req = int'($signed(raw));
    ok = (req > -ANGLE_LIMIT) && (req < ANGLE_LIMIT);
    if (ok) angle_mem[idx] = req[15:0];
    ang = angle_mem[idx];
    pos = tilt_to_steps(ang);
    if (ofs_en && (idx[4:1] == ofs_mirror))
      pos += idx[0] ? int'(ofs_y) : int'(ofs_x);
    posu = pos[17:0];
    chg = (posu != steps_mem[idx]);
    steps_mem[idx] = posu;
    return {chg, posu};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_ENABLE: ofs_en = val[0];
      REG_OFFSET_MIRROR: ofs_mirror = val[3:0];
      REG_OFFSET_X:      ofs_x = val;
      default:           ofs_y = val;
    endcase
  endtask

  // send one word; fixed expectation used when has_fixed is set
  task automatic send_word(logic [4:0] idx, logic [17:0] raw,
                           bit has_fixed, logic [18:0] fixed);
    logic [18:0] exp_word;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 27) @(negedge clk);
    exp_word = predict_step(idx, raw);
    if (has_fixed) exp_word = fixed;
    pending_q.push_back(exp_word);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, raw, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk)
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        logic [18:0] e;
        e = pending_q.pop_front();
        if (m_tdata[17:0] !== e[17:0] || m_tdata[18] !== e[18]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pos %h chg %b, got pos %h chg %b",
                     e[17:0], e[18], m_tdata[17:0], m_tdata[18]);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word and no config write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  typedef struct {
    logic [4:0]  idx;
    logic [17:0] raw;
    bit          has_fixed;
    logic [18:0] fixed;
  } stim_row_t;

  stim_row_t dir_tab [] = '{
    '{5'd0,  18'd0,      1'b1, 19'd0},          // zero after reset: no change
    '{5'd1,  18'd0,      1'b1, 19'd0},
    '{5'd0,  18'd29999,  1'b0, 19'd0},
    '{5'd0,  -18'sd29999, 1'b0, 19'd0},
    '{5'd2,  18'd30000,  1'b1, 19'd0},          // out of range, stored zero
    '{5'd3,  -18'sd30000, 1'b1, 19'd0},
    '{5'd4,  18'h1ffff,  1'b1, 19'd0},
    '{5'd5,  18'h20000,  1'b1, 19'd0},
    '{5'd6,  18'd15000,  1'b0, 19'd0},
    '{5'd6,  18'd15000,  1'b0, 19'd0},          // repeat: no change
    '{5'd6,  18'd31000,  1'b0, 19'd0},          // ignored, stored used
    '{5'd31, 18'd12345,  1'b0, 19'd0},
    '{5'd30, -18'sd12345, 1'b0, 19'd0},
    '{5'd7,  18'd1,      1'b0, 19'd0},
    '{5'd8,  -18'sd1,    1'b0, 19'd0}
  };

  logic [4:0]  r_idx;
  logic [17:0] r_raw;
  int sel;

  initial begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      angle_mem[i] = '0;
      steps_mem[i] = '0;
    end
    ofs_en = 0; ofs_mirror = 0; ofs_x = 0; ofs_y = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i])
      send_word(dir_tab[i].idx, dir_tab[i].raw, dir_tab[i].has_fixed, dir_tab[i].fixed);
    drain();

    // offset settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_OFFSET_ENABLE, 16'd1);
          write_reg(REG_OFFSET_MIRROR, 16'd15);
          write_reg(REG_OFFSET_X, 16'h7fff);
          write_reg(REG_OFFSET_Y, 16'h8000);
        end
        1: begin
          write_reg(REG_OFFSET_MIRROR, 16'd0);
          write_reg(REG_OFFSET_X, 16'h8000);
          write_reg(REG_OFFSET_Y, 16'h7fff);
        end
        2: write_reg(REG_OFFSET_ENABLE, 16'd0);
        default: begin
          write_reg(REG_OFFSET_ENABLE, 16'($urandom_range(1)));
          write_reg(REG_OFFSET_MIRROR, 16'($urandom));
          write_reg(REG_OFFSET_X, 16'($urandom));
          write_reg(REG_OFFSET_Y, 16'($urandom));
        end
      endcase
      no_idle = (ph == 4);
      for (int n = 0; n < 125; n++) begin
        r_idx = (ph < 2 && $urandom_range(1)) ? {ofs_mirror, 1'($urandom)}
                                                : 5'($urandom);
        sel = $urandom_range(9);
        if (sel < 6) r_raw = 18'($signed($urandom_range(59998)) - 29999);
        else if (sel < 8) r_raw = 18'($urandom);
        else r_raw = 18'($signed($urandom_range(3)) - 1);
        send_word(r_idx, r_raw, 1'b0, '0);
      end
      drain();
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: mirror_angle_to_stepper_steps.f
hdl/mats_pkg.sv
hdl/mats_cordic.sv
hdl/mats_sqrt.sv
hdl/mirror_angle_to_stepper_steps.sv
hdl/mats_checker.sv
dv/tb.sv
